// ----- design/ewmn_pkg.sv -----
// ============================================================================
// ewmn_pkg
// shared types, codes and constants of the echo width to midi note core
// ============================================================================
package ewmn_pkg;

    // timer width of the capture unit
    localparam int CNT_BITS = 16;

    // event kinds carried in tuser
    localparam logic [1:0] MODE_OVF  = 2'd0;
    localparam logic [1:0] MODE_EDGE = 2'd1;
    localparam logic [1:0] MODE_POLL = 2'd2;

    // midi status bytes
    localparam logic [7:0] MSG_ON  = 8'h90;
    localparam logic [7:0] MSG_OFF = 8'h80;

    // register indexes
    localparam logic [2:0] CFG_BASELINE = 3'd0;
    localparam logic [2:0] CFG_MARGIN   = 3'd1;
    localparam logic [2:0] CFG_OFFSET   = 3'd2;
    localparam logic [2:0] CFG_SPAN     = 3'd3;
    localparam logic [2:0] CFG_VELOCITY = 3'd4;

    // register reset values
    localparam logic [15:0] RST_BASELINE = 16'd0;
    localparam logic [15:0] RST_MARGIN   = 16'd1000;
    localparam logic [15:0] RST_OFFSET   = 16'd30;
    localparam logic [15:0] RST_SPAN     = 16'd765;
    localparam logic [6:0]  RST_VELOCITY = 7'd100;

    // overflow counter ceiling
    localparam logic [15:0] WRAP_MAX = 16'hFFFF;

    // divide by 3 for values below 2^16: (x * 43691) >> 17
    localparam logic [16:0] DIV3_RECIP = 17'd43691;
    localparam int          DIV3_SHIFT = 17;

    // byte index of the last beat of a one- or two-message burst
    localparam logic [2:0] LAST_ONE = 3'd2;
    localparam logic [2:0] LAST_TWO = 3'd5;

    typedef struct packed {
        logic [15:0] baseline;
        logic [15:0] margin;
        logic [15:0] offset;
        logic [15:0] span;
        logic [6:0]  velocity;
    } t_cfg;

    // one poll's worth of midi bytes
    typedef struct packed {
        logic [7:0] status0;   // first message status
        logic [7:0] note0;     // first message note
        logic [7:0] note1;     // second (note-on) message note
        logic       two;       // second message present
        logic       held;      // pressed state after the poll
    } t_burst;

endpackage

// ----- design/ewmn_note_map.sv -----
// ============================================================================
// ewmn_note_map
// maps the measured echo width to a note number
// ============================================================================
module ewmn_note_map (
    input  logic [31:0] i_width,
    input  logic [15:0] i_offset,
    input  logic [15:0] i_span,
    output logic [7:0]  o_note
);

    logic [31:0] adj;
    logic        in_range;
    logic [32:0] prod;
    logic [15:0] quot;

    assign adj      = i_width - {16'd0, i_offset};
    assign in_range = (i_width >= {16'd0, i_offset}) && (adj <= {16'd0, i_span});
    // adj fits 16 bits whenever it is in range
    assign prod     = {17'd0, adj[15:0]} * {16'd0, ewmn_pkg::DIV3_RECIP};
    assign quot     = prod[ewmn_pkg::DIV3_SHIFT +: 16];

    always_comb begin
        if (!in_range) begin
            o_note = 8'd0;
        end else if (quot > 16'd255) begin
            o_note = 8'd255;
        end else begin
            o_note = quot[7:0];
        end
    end

endmodule

// ----- design/ewmn_event.sv -----
// ============================================================================
// ewmn_event
// input register, echo measurement state and poll decision
// ============================================================================
module ewmn_event (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [1:0]            i_mode,
    input  logic [15:0]           i_capture,
    input  logic [15:0]           i_touch,
    input  ewmn_pkg::t_cfg        i_cfg,
    input  logic                  i_tx_free,
    output logic                  o_load,
    output ewmn_pkg::t_burst      o_burst
);

    logic        r_in_valid;
    logic [1:0]  r_in_mode;
    logic [15:0] r_in_cap;
    logic [15:0] r_in_touch;

    logic        r_pressed;
    logic [7:0]  r_cur_note;
    logic [31:0] r_width;
    logic [15:0] r_start;
    logic [15:0] r_wrap;
    logic        r_await;

    logic        n_pressed;
    logic [7:0]  n_cur_note;
    logic [31:0] n_width;
    logic [15:0] n_start;
    logic [15:0] n_wrap;
    logic        n_await;

    logic        fire;
    logic        touched;
    logic [7:0]  new_note;
    logic [31:0] meas;

    assign fire       = r_in_valid && ((r_in_mode != ewmn_pkg::MODE_POLL) || i_tx_free);
    assign o_s_tready = !r_in_valid || fire;

    assign touched = {1'b0, r_in_touch} > ({1'b0, i_cfg.baseline} + {1'b0, i_cfg.margin});

    // cap + wrap * (2^CNT_BITS - 1) - start, modulo 2^32
    assign meas = {16'd0, r_in_cap} + (({16'd0, r_wrap} << ewmn_pkg::CNT_BITS)
                  - {16'd0, r_wrap}) - {16'd0, r_start};

    ewmn_note_map u_note_map (
        .i_width  (r_width),
        .i_offset (i_cfg.offset),
        .i_span   (i_cfg.span),
        .o_note   (new_note)
    );

    always_comb begin
        n_pressed  = r_pressed;
        n_cur_note = r_cur_note;
        n_width    = r_width;
        n_start    = r_start;
        n_wrap     = r_wrap;
        n_await    = r_await;
        o_load     = 1'b0;
        o_burst    = '0;
        if (fire) begin
            case (r_in_mode)
                ewmn_pkg::MODE_OVF: begin
                    if (r_wrap != ewmn_pkg::WRAP_MAX) begin
                        n_wrap = r_wrap + 16'd1;
                    end
                end
                ewmn_pkg::MODE_EDGE: begin
                    if (!r_pressed) begin
                        n_width = 32'd0;
                        n_start = 16'd0;
                        n_await = 1'b0;
                    end else if (!r_await) begin
                        n_start = r_in_cap;
                        n_wrap  = 16'd0;
                        n_await = 1'b1;
                    end else begin
                        n_width = meas;
                        n_start = 16'd0;
                        n_await = 1'b0;
                    end
                end
                ewmn_pkg::MODE_POLL: begin
                    if (touched) begin
                        o_load        = 1'b1;
                        n_pressed     = 1'b1;
                        n_cur_note    = new_note;
                        o_burst.held  = 1'b1;
                        if (!r_pressed) begin
                            o_burst.status0 = ewmn_pkg::MSG_ON;
                            o_burst.note0   = new_note;
                        end else begin
                            o_burst.status0 = ewmn_pkg::MSG_OFF;
                            o_burst.note0   = r_cur_note;
                            o_burst.note1   = new_note;
                            o_burst.two     = 1'b1;
                        end
                    end else if (r_pressed) begin
                        o_load          = 1'b1;
                        n_pressed       = 1'b0;
                        o_burst.status0 = ewmn_pkg::MSG_OFF;
                        o_burst.note0   = r_cur_note;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pressed  <= 1'b0;
            r_cur_note <= 8'd0;
            r_width    <= 32'd0;
            r_start    <= 16'd0;
            r_wrap     <= 16'd0;
            r_await    <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            r_pressed  <= n_pressed;
            r_cur_note <= n_cur_note;
            r_width    <= n_width;
            r_start    <= n_start;
            r_wrap     <= n_wrap;
            r_await    <= n_await;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_mode  <= i_mode;
            r_in_cap   <= i_capture;
            r_in_touch <= i_touch;
        end
    end

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> i_tx_free)
        else $error("burst loaded while transmitter busy");

    a_held_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> (r_pressed == $past(o_burst.held)))
        else $error("pressed state disagrees with burst held flag");

    a_wrap_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_mode == ewmn_pkg::MODE_OVF && r_wrap == ewmn_pkg::WRAP_MAX)
        |=> (r_wrap == ewmn_pkg::WRAP_MAX))
        else $error("overflow counter wrapped");

endmodule

// ----- design/ewmn_tx.sv -----
// ============================================================================
// ewmn_tx
// holds one burst of midi messages and sends it one byte per beat
// ============================================================================
module ewmn_tx (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  ewmn_pkg::t_burst      i_burst,
    input  logic [6:0]            i_velocity,
    output logic                  o_free,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_byte,
    output logic                  o_last,
    output logic                  o_held
);

    logic                 r_busy;
    logic [2:0]           r_idx;
    ewmn_pkg::t_burst     r_burst;
    logic [6:0]           r_vel;

    logic                 last_beat;

    assign o_m_tvalid = r_busy;
    assign o_last     = r_idx == (r_burst.two ? ewmn_pkg::LAST_TWO : ewmn_pkg::LAST_ONE);
    assign o_held     = r_burst.held;
    assign last_beat  = r_busy && i_m_tready && o_last;
    assign o_free     = !r_busy || last_beat;

    always_comb begin
        case (r_idx)
            3'd0:    o_byte = r_burst.status0;
            3'd1:    o_byte = r_burst.note0;
            3'd2:    o_byte = {1'b0, r_vel};
            3'd3:    o_byte = ewmn_pkg::MSG_ON;
            3'd4:    o_byte = r_burst.note1;
            3'd5:    o_byte = {1'b0, r_vel};
            default: o_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (r_busy && i_m_tready) begin
            if (o_last) begin
                r_busy <= 1'b0;
                r_idx  <= 3'd0;
            end else begin
                r_idx  <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
            r_vel   <= i_velocity;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= (r_burst.two ? ewmn_pkg::LAST_TWO : ewmn_pkg::LAST_ONE)))
        else $error("byte index past end of burst");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(o_last && i_m_tready))
        else $error("burst ended before its last byte");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("burst overwritten while being sent");

endmodule

// ----- design/echo_width_to_midi_note_core.sv -----
// ============================================================================
// echo_width_to_midi_note_core
// measures echo widths between capture edges while the touch pad is held and
// turns touch polls into midi note-on / note-off byte streams
// ============================================================================
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  ---------------------------------
//  s (in)    input      i_s_tvalid/o_s_tready   tdata capture, touch; tuser mode
//  m (out)   output     o_m_tvalid/i_m_tready   tdata midi byte, held; tlast final
//  cfg       input      i_cfg_valid/o_cfg_ready index 0..4, 16-bit data
//
//  an event is held in the input register, then updates the measurement state;
//  overflow and edge events retire at one per cycle; a poll that changes nothing
//  loads no burst; note-on or note-off gives three output beats, a held re-trigger
//  six; the byte serializer (one beat per cycle while i_m_tready is high) sets the
//  poll rate, and a poll waits only until the previous burst's last beat
//  overflow and edge events pass while a burst is still being sent
//  synchronous active-low reset; no clearing pass, the block is ready right away
//
module echo_width_to_midi_note_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input events
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] capture_count, [31:16] touch_count
    input  logic [1:0]  i_s_tuser,   // [1:0] mode
    // midi bytes
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] midi_byte, [8] held, [15:9] zero
    output logic        o_m_tlast,   // final_byte
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    ewmn_pkg::t_cfg   r_cfg;
    ewmn_pkg::t_burst burst;
    logic             load;
    logic             tx_free;
    logic [7:0]       tx_byte;
    logic             tx_held;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.baseline <= ewmn_pkg::RST_BASELINE;
            r_cfg.margin   <= ewmn_pkg::RST_MARGIN;
            r_cfg.offset   <= ewmn_pkg::RST_OFFSET;
            r_cfg.span     <= ewmn_pkg::RST_SPAN;
            r_cfg.velocity <= ewmn_pkg::RST_VELOCITY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ewmn_pkg::CFG_BASELINE: r_cfg.baseline <= i_cfg_data;
                ewmn_pkg::CFG_MARGIN:   r_cfg.margin   <= i_cfg_data;
                ewmn_pkg::CFG_OFFSET:   r_cfg.offset   <= i_cfg_data;
                ewmn_pkg::CFG_SPAN:     r_cfg.span     <= i_cfg_data;
                ewmn_pkg::CFG_VELOCITY: r_cfg.velocity <= i_cfg_data[6:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // event register, echo width measurement and touch decision
    ewmn_event u_event (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_mode     (i_s_tuser),
        .i_capture  (i_s_tdata[15:0]),
        .i_touch    (i_s_tdata[31:16]),
        .i_cfg      (r_cfg),
        .i_tx_free  (tx_free),
        .o_load     (load),
        .o_burst    (burst)
    );

    // midi byte serializer
    ewmn_tx u_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_burst    (burst),
        .i_velocity (r_cfg.velocity),
        .o_free     (tx_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_byte     (tx_byte),
        .o_last     (o_m_tlast),
        .o_held     (tx_held)
    );

    assign o_m_tdata = {7'd0, tx_held, tx_byte};

endmodule
